@@ rtl/bpc_pkg.sv @@
package bpc_pkg;

  // Field and register widths.
  localparam int RAW_W   = 24;
  localparam int COEF_W  = 16;
  localparam int TEMP_W  = 20;
  localparam int PRES_W  = 32;
  localparam int CIDX_W  = 3;

  // Number of register stages from the input beat to the output register.
  localparam int STAGES = 8;

  // Temperature thresholds of the second-order correction, in 0.01 degC.
  localparam logic signed [TEMP_W-1:0] T_BASE = 20'sd2000;
  localparam logic signed [TEMP_W-1:0] T_LOW  = -20'sd1500;

  // Calibration register indexes.
  typedef enum logic [CIDX_W-1:0] {
    CFG_PRESSURE_SENSITIVITY   = 3'd0,
    CFG_PRESSURE_OFFSET        = 3'd1,
    CFG_SENSITIVITY_TEMP_COEFF = 3'd2,
    CFG_OFFSET_TEMP_COEFF      = 3'd3,
    CFG_REFERENCE_TEMPERATURE  = 3'd4,
    CFG_TEMPERATURE_GAIN       = 3'd5
  } cfg_idx_t;

endpackage

@@ rtl/baro_pressure_temp_compensation.sv @@
// Second-order barometric compensation pipeline.
//
// Input channel: one beat carries a raw 24-bit pressure conversion and a raw
// 24-bit temperature conversion, taken when in_valid and in_ready are both high.
// Output channel: one beat carries the compensated temperature (0.01 degC,
// 20-bit two's complement) and pressure (0.01 mbar, wrapped to 32 bits).
// Calibration: six 16-bit coefficients written through cfg_wr_en, cfg_index
// and cfg_wdata; indexes six and seven are ignored. Write them only while no
// beat is in flight.
//
// Pipeline: a beat passes through eight register stages, the last of which
// is the output register. Throughput: one beat per cycle while the receiver
// does not stall, set by the eight-stage pipeline in which the widest unit
// is a split 24 by 41 bit multiplier.
// Reset (rst_n low, synchronous) empties every stage and clears the
// coefficients to zero. When the receiver stalls, each stage holds its beat
// only if the stage after it is full and also held, so bubbles close up and
// the input keeps being taken until the whole pipeline is full.
module baro_pressure_temp_compensation (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [bpc_pkg::RAW_W-1:0]          in_raw_pressure,
  input  logic [bpc_pkg::RAW_W-1:0]          in_raw_temperature,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [bpc_pkg::TEMP_W-1:0]  out_temperature_centi,
  output logic signed [bpc_pkg::PRES_W-1:0]  out_pressure_centi,
  input  logic                               cfg_wr_en,
  input  logic [bpc_pkg::CIDX_W-1:0]         cfg_index,
  input  logic [bpc_pkg::COEF_W-1:0]         cfg_wdata
);
  import bpc_pkg::*;

  // Calibration coefficients C1 to C6.
  logic [COEF_W-1:0] c1_r, c2_r, c3_r, c4_r, c5_r, c6_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c1_r <= '0;
      c2_r <= '0;
      c3_r <= '0;
      c4_r <= '0;
      c5_r <= '0;
      c6_r <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_idx_t'(cfg_index))
        CFG_PRESSURE_SENSITIVITY:   c1_r <= cfg_wdata;
        CFG_PRESSURE_OFFSET:        c2_r <= cfg_wdata;
        CFG_SENSITIVITY_TEMP_COEFF: c3_r <= cfg_wdata;
        CFG_OFFSET_TEMP_COEFF:      c4_r <= cfg_wdata;
        CFG_REFERENCE_TEMPERATURE:  c5_r <= cfg_wdata;
        CFG_TEMPERATURE_GAIN:       c6_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // ------------------------------------------------------------------------
  // Flow control. A stage loads when it is empty or when the stage after it
  // loads in the same cycle; the output register counts as the last stage.
  // ------------------------------------------------------------------------
  logic [STAGES:1] v_r, v_nxt, adv;

  always_comb begin
    adv[STAGES] = !v_r[STAGES] || out_ready;
    for (int i = STAGES - 1; i >= 1; i--) begin
      adv[i] = !v_r[i] || adv[i+1];
    end
    v_nxt[1] = adv[1] ? in_valid : v_r[1];
    for (int i = 2; i <= STAGES; i++) begin
      v_nxt[i] = adv[i] ? v_r[i-1] : v_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  assign in_ready  = adv[1];
  assign out_valid = v_r[STAGES];

  // ------------------------------------------------------------------------
  // Stage 1: dT = D2 - C5 * 256, which always fits 25 signed bits.
  // ------------------------------------------------------------------------
  logic signed [24:0]     dt_r, dt_nxt;
  logic [RAW_W-1:0]       d1_s1_r;

  assign dt_nxt = $signed({1'b0, in_raw_temperature}) - $signed({1'b0, c5_r, 8'd0});

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      dt_r    <= dt_nxt;
      d1_s1_r <= in_raw_pressure;
    end
  end

  // ------------------------------------------------------------------------
  // Stage 2: the four products of dT (with C6, C4, C3 and with itself).
  // ------------------------------------------------------------------------
  logic signed [41:0] pt_r, pt_nxt, po_r, po_nxt, ps_r, ps_nxt;
  logic signed [49:0] sq_r, sq_nxt;
  logic [RAW_W-1:0]   d1_s2_r;

  assign pt_nxt = dt_r * $signed({1'b0, c6_r});
  assign po_nxt = dt_r * $signed({1'b0, c4_r});
  assign ps_nxt = dt_r * $signed({1'b0, c3_r});
  assign sq_nxt = dt_r * dt_r;

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      pt_r    <= pt_nxt;
      po_r    <= po_nxt;
      ps_r    <= ps_nxt;
      sq_r    <= sq_nxt;
      d1_s2_r <= d1_s1_r;
    end
  end

  // ------------------------------------------------------------------------
  // Stage 3: first-order TEMP, OFF and SENS, and T2 = dT^2 / 2^31.
  // Signed divisions by powers of two round toward zero: a negative value is
  // biased by the divisor less one before the arithmetic shift.
  // ------------------------------------------------------------------------
  logic signed [41:0]       pt_b, po_b, ps_b;
  logic signed [TEMP_W-1:0] temp_r, temp_nxt;
  logic signed [35:0]       off_r, off_nxt, sens_r, sens_nxt;
  logic [17:0]              t2_r, t2_nxt;
  logic [RAW_W-1:0]         d1_s3_r;

  always_comb begin
    pt_b     = pt_r + (pt_r[41] ? 42'sd8388607 : 42'sd0);
    po_b     = po_r + (po_r[41] ? 42'sd127 : 42'sd0);
    ps_b     = ps_r + (ps_r[41] ? 42'sd255 : 42'sd0);
    temp_nxt = T_BASE + $signed({pt_b[41], pt_b[41:23]});
    off_nxt  = $signed({4'd0, c2_r, 16'd0}) + $signed({po_b[41], po_b[41:7]});
    sens_nxt = $signed({5'd0, c1_r, 15'd0}) + $signed({{2{ps_b[41]}}, ps_b[41:8]});
    t2_nxt   = sq_r[48:31];
  end

  always_ff @(posedge clk) begin
    if (adv[3]) begin
      temp_r  <= temp_nxt;
      off_r   <= off_nxt;
      sens_r  <= sens_nxt;
      t2_r    <= t2_nxt;
      d1_s3_r <= d1_s2_r;
    end
  end

  // ------------------------------------------------------------------------
  // Stage 4: squares of (TEMP - 2000) and (TEMP + 1500), the two range flags
  // and the final temperature. Both squares stay below 2^35 wherever they
  // are used, so 36 bits hold them.
  // ------------------------------------------------------------------------
  logic signed [20:0]       a_s, b_s;
  logic signed [41:0]       a2_full, b2_full;
  logic [35:0]              a2_r, a2_nxt, b2_r, b2_nxt;
  logic                     lt_base_r, lt_base_nxt, lt_low_r, lt_low_nxt;
  logic signed [TEMP_W-1:0] tout_s4_r, tout_nxt;
  logic signed [35:0]       off_s4_r, sens_s4_r;
  logic [RAW_W-1:0]         d1_s4_r;

  always_comb begin
    a_s         = $signed({temp_r[TEMP_W-1], temp_r}) - 21'sd2000;
    b_s         = $signed({temp_r[TEMP_W-1], temp_r}) + 21'sd1500;
    a2_full     = a_s * a_s;
    b2_full     = b_s * b_s;
    a2_nxt      = a2_full[35:0];
    b2_nxt      = b2_full[35:0];
    lt_base_nxt = temp_r < T_BASE;
    lt_low_nxt  = temp_r < T_LOW;
    tout_nxt    = lt_base_nxt ? temp_r - $signed({2'd0, t2_r}) : temp_r;
  end

  always_ff @(posedge clk) begin
    if (adv[4]) begin
      a2_r      <= a2_nxt;
      b2_r      <= b2_nxt;
      lt_base_r <= lt_base_nxt;
      lt_low_r  <= lt_low_nxt;
      tout_s4_r <= tout_nxt;
      off_s4_r  <= off_r;
      sens_s4_r <= sens_r;
      d1_s4_r   <= d1_s3_r;
    end
  end

  // ------------------------------------------------------------------------
  // Stage 5: OFF2 and SENS2, subtracted from OFF and SENS. Every term is
  // non-negative, so its halving and quartering are plain shifts.
  // ------------------------------------------------------------------------
  logic [37:0]              sq5;
  logic [39:0]              b7, b11, off2, sens2;
  logic signed [40:0]       offc_r, offc_nxt, sensc_r, sensc_nxt;
  logic signed [TEMP_W-1:0] tout_s5_r;
  logic [RAW_W-1:0]         d1_s5_r;

  always_comb begin
    sq5   = {2'd0, a2_r} + {a2_r, 2'd0};
    b7    = {1'b0, b2_r, 3'd0} - {4'd0, b2_r};
    b11   = {1'b0, b2_r, 3'd0} + {3'd0, b2_r, 1'b0} + {4'd0, b2_r};
    off2  = '0;
    sens2 = '0;
    if (lt_base_r) begin
      off2  = {3'd0, sq5[37:1]};
      sens2 = {4'd0, sq5[37:2]};
      if (lt_low_r) begin
        off2  = off2 + b7;
        sens2 = sens2 + {1'b0, b11[39:1]};
      end
    end
    offc_nxt  = $signed({{5{off_s4_r[35]}}, off_s4_r}) - $signed({1'b0, off2});
    sensc_nxt = $signed({{5{sens_s4_r[35]}}, sens_s4_r}) - $signed({1'b0, sens2});
  end

  always_ff @(posedge clk) begin
    if (adv[5]) begin
      offc_r    <= offc_nxt;
      sensc_r   <= sensc_nxt;
      tout_s5_r <= tout_s4_r;
      d1_s5_r   <= d1_s4_r;
    end
  end

  // ------------------------------------------------------------------------
  // Stage 6: D1 * SENS as two partial products over the low 21 bits and the
  // signed high 20 bits of SENS.
  // ------------------------------------------------------------------------
  logic [44:0]              pp_lo_r, pp_lo_nxt;
  logic signed [44:0]       pp_hi_r, pp_hi_nxt;
  logic signed [40:0]       offc_s6_r;
  logic signed [TEMP_W-1:0] tout_s6_r;

  assign pp_lo_nxt = d1_s5_r * sensc_r[20:0];
  assign pp_hi_nxt = $signed({1'b0, d1_s5_r}) * $signed(sensc_r[40:21]);

  always_ff @(posedge clk) begin
    if (adv[6]) begin
      pp_lo_r   <= pp_lo_nxt;
      pp_hi_r   <= pp_hi_nxt;
      offc_s6_r <= offc_r;
      tout_s6_r <= tout_s5_r;
    end
  end

  // ------------------------------------------------------------------------
  // Stage 7: join the partial products, divide by 2^21 and subtract OFF.
  // ------------------------------------------------------------------------
  logic signed [65:0]       prod, prod_b;
  logic signed [45:0]       x_r, x_nxt;
  logic signed [TEMP_W-1:0] tout_s7_r;

  always_comb begin
    prod   = $signed({pp_hi_r, 21'd0}) + $signed({21'd0, pp_lo_r});
    prod_b = prod + (prod[65] ? 66'sd2097151 : 66'sd0);
    x_nxt  = $signed({prod_b[65], prod_b[65:21]})
           - $signed({{5{offc_s6_r[40]}}, offc_s6_r});
  end

  always_ff @(posedge clk) begin
    if (adv[7]) begin
      x_r       <= x_nxt;
      tout_s7_r <= tout_s6_r;
    end
  end

  // ------------------------------------------------------------------------
  // Stage 8: final division by 2^15 into the output register. The quotient
  // fits 31 bits, so sign extension is the wrap to 32.
  // ------------------------------------------------------------------------
  logic signed [45:0]       x_b;
  logic signed [PRES_W-1:0] pres_r, pres_nxt;
  logic signed [TEMP_W-1:0] tout_r;

  always_comb begin
    x_b      = x_r + (x_r[45] ? 46'sd32767 : 46'sd0);
    pres_nxt = $signed({x_b[45], x_b[45:15]});
  end

  always_ff @(posedge clk) begin
    if (adv[8]) begin
      pres_r <= pres_nxt;
      tout_r <= tout_s7_r;
    end
  end

  assign out_temperature_centi = tout_r;
  assign out_pressure_centi    = pres_r;

endmodule

@@ rtl/bpc_checker.sv @@
module bpc_checker (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_ready,
  input  logic                               out_valid,
  input  logic                               out_ready,
  input  logic signed [bpc_pkg::TEMP_W-1:0]  out_temperature_centi,
  input  logic signed [bpc_pkg::PRES_W-1:0]  out_pressure_centi
);
  import bpc_pkg::*;

  // A stalled result beat holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_temperature_centi)
                                && $stable(out_pressure_centi))
    else $error("result beat changed while stalled");

  // The pipeline only pushes back when the output stage is full and held.
  a_no_false_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid || out_ready |-> in_ready)
    else $error("input stalled with the output free");

  // Reset empties the pipeline.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result beat shown straight after reset");

  // The compensated temperature always lies within plus or minus 2^18.
  a_temp_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_temperature_centi[TEMP_W-1] == out_temperature_centi[TEMP_W-2])
    else $error("temperature outside its reachable range");

endmodule

bind baro_pressure_temp_compensation bpc_checker u_bpc_checker (.*);

@@ verif/testbench.sv @@
`timescale 1ns / 100ps

// Testbench for the second-order barometric compensation pipeline.
//
// A small scoreboard class keeps its own copy of the six calibration
// coefficients and a queue of compensated readings still to come out of the
// block. Each input beat taken by the block is run through the scoreboard's own
// compensation arithmetic, and each output beat is compared field by field
// with the oldest reading in that queue. The drivers below are plain tasks.
module testbench;
  import bpc_pkg::*;

  localparam int CLK_PERIOD   = 12;
  localparam int RESET_CYCLES = 11;
  // Generous bound on the whole run; the slowest correct run needs far less.
  localparam int LIMIT_CYCLES = 400_000;
  localparam int RAW_MAX      = (1 << RAW_W) - 1;
  localparam int COEF_MAX     = (1 << COEF_W) - 1;

  // Register indexes that the block has no register for; writes are dropped.
  localparam logic [CIDX_W-1:0] CFG_SPARE_LOW  = 3'd6;
  localparam logic [CIDX_W-1:0] CFG_SPARE_HIGH = 3'd7;

  // A typical factory calibration, used for the directed beats.
  localparam logic [COEF_W-1:0] TYP_C1 = 16'd40127;
  localparam logic [COEF_W-1:0] TYP_C2 = 16'd36924;
  localparam logic [COEF_W-1:0] TYP_C3 = 16'd23317;
  localparam logic [COEF_W-1:0] TYP_C4 = 16'd23282;
  localparam logic [COEF_W-1:0] TYP_C5 = 16'd33464;
  localparam logic [COEF_W-1:0] TYP_C6 = 16'd28312;

  typedef struct {
    logic signed [TEMP_W-1:0] temperature_centi;
    logic signed [PRES_W-1:0] pressure_centi;
  } compensated_t;

  class reading_ledger;
    logic [COEF_W-1:0] coeff [6];
    compensated_t      awaited [$];
    int                errors;
    int                checked;

    function new();
      foreach (coeff[i]) coeff[i] = '0;
      errors  = 0;
      checked = 0;
    endfunction

    function void set_coeff(logic [CIDX_W-1:0] idx, logic [COEF_W-1:0] val);
      if (idx <= CFG_TEMPERATURE_GAIN) coeff[idx] = val;
    endfunction

    function int pending();
      return awaited.size();
    endfunction

    // First-order terms, then the cold and very cold corrections. Every
    // intermediate is signed 64-bit and every division truncates toward zero.
    function compensated_t compensate(logic [RAW_W-1:0] raw_p, logic [RAW_W-1:0] raw_t);
      longint d1, d2, c1, c2, c3, c4, c5, c6;
      longint dt, temp, off, sens, t2, off2, sens2, a, sq5, b, sq, pres;
      compensated_t r;
      d1 = longint'(raw_p);
      d2 = longint'(raw_t);
      c1 = longint'(coeff[CFG_PRESSURE_SENSITIVITY]);
      c2 = longint'(coeff[CFG_PRESSURE_OFFSET]);
      c3 = longint'(coeff[CFG_SENSITIVITY_TEMP_COEFF]);
      c4 = longint'(coeff[CFG_OFFSET_TEMP_COEFF]);
      c5 = longint'(coeff[CFG_REFERENCE_TEMPERATURE]);
      c6 = longint'(coeff[CFG_TEMPERATURE_GAIN]);
      dt   = d2 - c5 * 256;
      temp = 2000 + (dt * c6) / 8388608;
      off  = c2 * 65536 + (c4 * dt) / 128;
      sens = c1 * 32768 + (c3 * dt) / 256;
      t2 = 0;
      off2 = 0;
      sens2 = 0;
      if (temp < 2000) begin
        a     = temp - 2000;
        sq5   = 5 * a * a;
        t2    = longint'(longint'(unsigned'(dt * dt)) >> 31);
        off2  = sq5 / 2;
        sens2 = sq5 / 4;
        if (temp < -1500) begin
          b     = temp + 1500;
          sq    = b * b;
          off2  = off2 + 7 * sq;
          sens2 = sens2 + (11 * sq) / 2;
        end
      end
      temp = temp - t2;
      off  = off - off2;
      sens = sens - sens2;
      pres = ((d1 * sens) / 2097152 - off) / 32768;
      r.temperature_centi = temp[TEMP_W-1:0];
      r.pressure_centi    = pres[PRES_W-1:0];
      return r;
    endfunction

    function void note_input(logic [RAW_W-1:0] raw_p, logic [RAW_W-1:0] raw_t);
      awaited.push_back(compensate(raw_p, raw_t));
    endfunction

    function void check_result(logic signed [TEMP_W-1:0] t, logic signed [PRES_W-1:0] p);
      compensated_t want;
      if (awaited.size() == 0) begin
        $error("result beat with no reading outstanding: temperature_centi %0d, pressure_centi %0d",
               t, p);
        errors++;
        return;
      end
      want = awaited.pop_front();
      checked++;
      if (t !== want.temperature_centi) begin
        $error("temperature_centi mismatch: expected %0d, actual %0d",
               want.temperature_centi, t);
        errors++;
      end
      if (p !== want.pressure_centi) begin
        $error("pressure_centi mismatch: expected %0d, actual %0d",
               want.pressure_centi, p);
        errors++;
      end
    endfunction
  endclass

  // Every input of the block starts at a known value.
  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic [RAW_W-1:0]         in_raw_pressure = '0;
  logic [RAW_W-1:0]         in_raw_temperature = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic signed [TEMP_W-1:0] out_temperature_centi;
  logic signed [PRES_W-1:0] out_pressure_centi;
  logic                     cfg_wr_en = 1'b0;
  logic [CIDX_W-1:0]        cfg_index = '0;
  logic [COEF_W-1:0]        cfg_wdata = '0;

  reading_ledger ledger;

  // Idling odds in percent, changed by the main sequence between phases.
  int tx_idle_pct = 22;
  int rx_idle_pct = 53;
  // Set by the main sequence to ask the receiver for one long hold-off.
  bit long_stall_req = 1'b0;
  int hold_left = 0;

  int readings_sent = 0;
  int calib_sets = 0;
  int backpressure_cycles = 0;

  always #(CLK_PERIOD / 2) clk = ~clk;

  baro_pressure_temp_compensation u_top (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_ready              (in_ready),
    .in_raw_pressure       (in_raw_pressure),
    .in_raw_temperature    (in_raw_temperature),
    .out_valid             (out_valid),
    .out_ready             (out_ready),
    .out_temperature_centi (out_temperature_centi),
    .out_pressure_centi    (out_pressure_centi),
    .cfg_wr_en             (cfg_wr_en),
    .cfg_index             (cfg_index),
    .cfg_wdata             (cfg_wdata)
  );

  // Receiver. It normally drops ready at random; when a long hold-off is
  // requested it keeps ready low for a counted stretch of its own, so that the
  // pipeline fills behind the output register and the input stalls.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left = hold_left - 1;
    end else if (long_stall_req) begin
      long_stall_req = 1'b0;
      hold_left = 120;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Output monitor. Values are sampled at the edge, before any of this edge's
  // updates, so the comparison does not depend on process order.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      ledger.check_result(out_temperature_centi, out_pressure_centi);
    if (rst_n && in_valid && !in_ready)
      backpressure_cycles++;
  end

  // One register write per edge. The enable is lowered by the caller once a
  // batch is done, so that it never drops and rises within the same step.
  task automatic write_register(input logic [CIDX_W-1:0] idx, input logic [COEF_W-1:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    ledger.set_coeff(idx, val);
  endtask

  task automatic load_coefficients(input logic [COEF_W-1:0] c1, c2, c3, c4, c5, c6);
    write_register(CFG_PRESSURE_SENSITIVITY, c1);
    write_register(CFG_PRESSURE_OFFSET, c2);
    write_register(CFG_SENSITIVITY_TEMP_COEFF, c3);
    write_register(CFG_OFFSET_TEMP_COEFF, c4);
    write_register(CFG_REFERENCE_TEMPERATURE, c5);
    write_register(CFG_TEMPERATURE_GAIN, c6);
    cfg_wr_en <= 1'b0;
    calib_sets++;
  endtask

  // Offers one beat after a random number of idle cycles and returns at the
  // edge that takes it. Valid stays high afterwards; the next call or the
  // caller decides whether it drops.
  task automatic send_reading(input logic [RAW_W-1:0] raw_p, input logic [RAW_W-1:0] raw_t);
    int gap;
    gap = 0;
    while (gap < 50 && $urandom_range(99) < tx_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid           <= 1'b1;
    in_raw_pressure    <= raw_p;
    in_raw_temperature <= raw_t;
    do @(posedge clk); while (!in_ready);
    ledger.note_input(raw_p, raw_t);
    readings_sent++;
  endtask

  // Stops offering and waits until every outstanding reading has come out,
  // then lets the pipeline's depth pass so that it is certainly empty.
  task automatic drain_pipeline();
    in_valid <= 1'b0;
    while (ledger.pending() != 0) @(posedge clk);
    repeat (STAGES + 2) @(posedge clk);
  endtask

  // Half the random beats put the temperature conversion within 2^21 counts of
  // the reference point, where the cold corrections switch in; the rest are
  // uniform over the whole 24-bit range.
  task automatic send_random_readings(input int count);
    longint centre, t;
    logic [RAW_W-1:0] raw_p;
    for (int i = 0; i < count; i++) begin
      raw_p = RAW_W'($urandom_range(RAW_MAX));
      if ($urandom_range(1) == 0) begin
        t = longint'($urandom_range(RAW_MAX));
      end else begin
        centre = longint'(ledger.coeff[CFG_REFERENCE_TEMPERATURE]) * 256;
        t = centre + longint'($urandom_range(1 << 22)) - (1 << 21);
        if (t < 0) t = 0;
        if (t > RAW_MAX) t = RAW_MAX;
      end
      send_reading(raw_p, t[RAW_W-1:0]);
    end
  endtask

  // Smallest negative dT (in magnitude) that pulls the first-order
  // temperature down by drop_centi with the given gain.
  function automatic longint dt_for_drop(input longint drop_centi, input longint gain);
    return -((drop_centi * 8388608 + gain - 1) / gain);
  endfunction

  function automatic logic [COEF_W-1:0] draw_coeff(input bit extremes_only);
    if (extremes_only) return {COEF_W{$urandom_range(1) == 1}};
    return COEF_W'($urandom_range(COEF_MAX));
  endfunction

  // Main sequence.
  initial begin
    longint ref_counts;
    bit     extremes;
    ledger = new();

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed beats under a typical calibration: the field extremes, the
    // textbook reading, the exact reference point, and temperatures either
    // side of the cold and very cold thresholds.
    load_coefficients(TYP_C1, TYP_C2, TYP_C3, TYP_C4, TYP_C5, TYP_C6);
    ref_counts = longint'(TYP_C5) * 256;
    send_reading('0, '0);
    send_reading(RAW_W'(RAW_MAX), RAW_W'(RAW_MAX));
    send_reading('0, RAW_W'(RAW_MAX));
    send_reading(RAW_W'(RAW_MAX), '0);
    send_reading(24'd9085466, 24'd8569150);
    send_reading(24'd9085466, RAW_W'(ref_counts));
    send_reading(24'd9085466, RAW_W'(ref_counts - 1));
    send_reading(24'd9085466, RAW_W'(ref_counts + dt_for_drop(1, TYP_C6)));
    send_reading(24'd9085466, RAW_W'(ref_counts + dt_for_drop(3500, TYP_C6)));
    send_reading(24'd9085466, RAW_W'(ref_counts + dt_for_drop(3501, TYP_C6)));
    send_reading(24'hAAAAAA, 24'h555555);
    send_reading(24'h555555, 24'hAAAAAA);
    drain_pipeline();

    // All coefficients at full scale: the widest products the block sees.
    load_coefficients('1, '1, '1, '1, '1, '1);
    send_reading('0, '0);
    send_reading(RAW_W'(RAW_MAX), RAW_W'(RAW_MAX));
    send_reading(RAW_W'(RAW_MAX), '0);
    send_reading('0, RAW_W'(RAW_MAX));
    drain_pipeline();

    // All coefficients at zero, then writes to the two spare indexes, which
    // must leave the calibration untouched.
    load_coefficients('0, '0, '0, '0, '0, '0);
    send_reading(RAW_W'(RAW_MAX), RAW_W'(RAW_MAX));
    send_reading('0, '0);
    drain_pipeline();
    write_register(CFG_SPARE_LOW, '1);
    write_register(CFG_SPARE_HIGH, '1);
    cfg_wr_en <= 1'b0;
    send_reading(RAW_W'(RAW_MAX), '0);
    send_reading('0, RAW_W'(RAW_MAX));
    drain_pipeline();

    // Random phases. Each third of them uses one idling profile: a lazy
    // receiver, then a lazy sender, then neither idles at all.
    for (int phase = 0; phase < 9; phase++) begin
      case (phase / 3)
        0: begin
          tx_idle_pct = 22;
          rx_idle_pct = 53;
        end
        1: begin
          tx_idle_pct = 53;
          rx_idle_pct = 22;
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
        end
      endcase
      drain_pipeline();
      case (phase)
        0: load_coefficients(TYP_C1, TYP_C2, TYP_C3, TYP_C4, TYP_C5, TYP_C6);
        1: load_coefficients('1, '1, '1, '1, '1, '1);
        2: load_coefficients('0, '0, '0, '0, '0, '0);
        default: begin
          extremes = (phase == 3 || phase == 6);
          load_coefficients(draw_coeff(extremes), draw_coeff(extremes), draw_coeff(extremes),
                            draw_coeff(extremes), draw_coeff(extremes), draw_coeff(extremes));
        end
      endcase

      // Once, hold the receiver off for a long stretch while the sender
      // keeps offering back to back, so the input stalls on a full pipeline.
      if (phase == 4) begin
        tx_idle_pct = 0;
        long_stall_req = 1'b1;
        send_random_readings(40);
        tx_idle_pct = 53;
      end

      send_random_readings(215);
    end

    drain_pipeline();

    $display("Compensated %0d readings, %0d results checked, over %0d calibration sets.",
             readings_sent, ledger.checked, calib_sets);
    $display("Input beats were held back by a full pipeline for %0d cycles; %0d mismatches.",
             backpressure_cycles, ledger.errors);
    if (ledger.errors == 0 && ledger.pending() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Watchdog: a hung handshake ends the run here.
  initial begin
    #(LIMIT_CYCLES * CLK_PERIOD);
    $error("run did not finish within %0d cycles", LIMIT_CYCLES);
    $display("TEST FAILED");
    $finish;
  end

endmodule
